[design/mtfps_pkg.sv]
package mtfps_pkg;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BLACK_POINT   = 2'd0;
  localparam cfg_idx_t CFG_WHITE_POINT   = 2'd1;
  localparam cfg_idx_t CFG_MIDTONE_LEVEL = 2'd2;
  localparam cfg_idx_t CFG_MASK_ENABLE   = 2'd3;

  // Reset value of the midtone register
  localparam logic [31:0] MIDTONE_RESET = 32'd16384;

endpackage

[design/mtfps_div.sv]
module mtfps_div import mtfps_pkg::*; #(
  parameter int QB = 16,
  parameter int DB = 16,
  parameter int SB = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [QB+DB-1:0] in_num,
  input  logic [DB-1:0]    in_den,
  input  logic [SB-1:0]    in_side,
  output logic             out_valid,
  output logic [QB-1:0]    out_q,
  output logic [SB-1:0]    out_side
);

  // Restoring divider, one quotient bit per stage. Needs in_num < in_den << QB.
  logic [DB-1:0] rem_r  [QB+1];
  logic [DB-1:0] den_r  [QB+1];
  logic [QB-1:0] low_r  [QB+1];
  logic [QB-1:0] q_r    [QB+1];
  logic [SB-1:0] side_r [QB+1];
  logic          v_r    [QB+1];

  assign rem_r[0]  = in_num[QB+DB-1:QB];
  assign low_r[0]  = in_num[QB-1:0];
  assign den_r[0]  = in_den;
  assign q_r[0]    = '0;
  assign side_r[0] = in_side;
  assign v_r[0]    = in_valid;

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [DB:0] trial;
    logic        ge;

    assign trial = {rem_r[g], low_r[g][QB-1]};
    assign ge    = (trial >= {1'b0, den_r[g]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else if (en) begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1]  <= ge ? DB'(trial - {1'b0, den_r[g]}) : trial[DB-1:0];
        low_r[g+1]  <= {low_r[g][QB-2:0], 1'b0};
        q_r[g+1]    <= {q_r[g][QB-2:0], ge};
        den_r[g+1]  <= den_r[g];
        side_r[g+1] <= side_r[g];
      end
    end
  end

  assign out_valid = v_r[QB];
  assign out_q     = q_r[QB];
  assign out_side  = side_r[QB];

endmodule

[design/midtone_transfer_pixel_stretch_unit.sv]
// Path: the S1 register, divider 1, S2, S3, divider 2, S4, then the output register.
// Throughput: one pixel per cycle unless the output stalls; two PIXEL_BITS-stage restoring
// dividers set the depth, and the blend divide by full scale is a fold-and-add in the output stage.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n, synchronous, active low) clears all valid bits and loads register
// defaults: black 0, white full scale, midtone 16384, masking off.
module midtone_transfer_pixel_stretch_unit import mtfps_pkg::*; #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // config write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  cfg_idx_t                               cfg_index,
  input  logic [PIXEL_BITS-1:0]                  cfg_data,
  // input stream; tdata from bit 0 up: pixel_in, mask_weight
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((2*PIXEL_BITS+7)/8)*8-1:0]      in_tdata,
  // output stream; tdata = pixel_out
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((PIXEL_BITS+7)/8)*8-1:0]        out_tdata
);

  localparam int N     = PIXEL_BITS;
  localparam int OUT_W = ((N+7)/8)*8;
  localparam logic [N-1:0] FS = '1;
  localparam longint MLO_L = ((longint'(1) << N) - 1 + 5000) / 10000;
  localparam logic [N-1:0] MLO = (MLO_L == 0) ? N'(1) : N'(MLO_L);
  localparam logic [N-1:0] MHI = FS - MLO;

  // ---------------- configuration registers ----------------
  logic [N-1:0] black_r, white_r, mid_r;
  logic         mask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_r <= '0;
      white_r <= FS;
      mid_r   <= N'(MIDTONE_RESET);
      mask_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BLACK_POINT:   black_r <= cfg_data;
        CFG_WHITE_POINT:   white_r <= cfg_data;
        CFG_MIDTONE_LEVEL: mid_r   <= cfg_data;
        CFG_MASK_ENABLE:   mask_r  <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // Clamped midtone
  logic [N-1:0] m_c;
  assign m_c = (mid_r < MLO) ? MLO : ((mid_r > MHI) ? MHI : mid_r);

  // ---------------- global stall ----------------
  logic out_valid_r;
  logic en;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---------------- S1: normalize numerator ----------------
  logic [N-1:0]   p_in, w_in, rng, pb;
  logic [2*N-1:0] num1_nxt;
  logic           byp_in;

  assign p_in     = in_tdata[N-1:0];
  assign w_in     = in_tdata[2*N-1:N];
  assign rng      = white_r - black_r;
  assign pb       = p_in - black_r;
  assign num1_nxt = ({N'(0), pb} * {N'(0), FS}) + (2*N)'(rng >> 1);
  // empty range or zero weight under masking passes the pixel through
  assign byp_in   = (white_r <= black_r) || (mask_r && (w_in == '0));

  logic           v1_r;
  logic [2*N-1:0] num1_r;
  logic [N-1:0]   rng1_r, p1_r, w1_r;
  logic           byp1_r, xz1_r, xf1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1_r <= num1_nxt;
      rng1_r <= (white_r > black_r) ? rng : N'(1);
      p1_r   <= p_in;
      w1_r   <= w_in;
      byp1_r <= byp_in;
      xz1_r  <= (p_in <= black_r);
      xf1_r  <= (p_in >= white_r);
    end
  end

  // ---------------- divider 1: x = (p-b)*FS/(w-b) ----------------
  localparam int SB1 = 2*N + 3;
  logic           v1d;
  logic [N-1:0]   q1;
  logic [SB1-1:0] side1;

  mtfps_div #(.QB(N), .DB(N), .SB(SB1)) u_div_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v1_r),
    .in_num   (num1_r),
    .in_den   (rng1_r),
    .in_side  ({w1_r, p1_r, byp1_r, xz1_r, xf1_r}),
    .out_valid(v1d),
    .out_q    (q1),
    .out_side (side1)
  );

  // ---------------- S2: MTF products ----------------
  logic [N-1:0] x2;
  assign x2 = side1[1] ? '0 : (side1[0] ? FS : q1);

  logic           v2_r;
  logic [2*N-1:0] a2_r, b2_r;
  logic [N-1:0]   x2_r, p2_r, w2_r;
  logic           byp2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r   <= {N'(0), FS - m_c} * {N'(0), x2};
      b2_r   <= {N'(0), m_c} * {N'(0), FS - x2};
      x2_r   <= x2;
      p2_r   <= side1[N+2:3];
      w2_r   <= side1[2*N+2:N+3];
      byp2_r <= side1[2];
    end
  end

  // ---------------- S3: MTF numerator and denominator ----------------
  logic [2*N:0]   den3;
  logic [3*N-1:0] num3_nxt;
  assign den3     = {1'b0, a2_r} + {1'b0, b2_r};
  assign num3_nxt = ({a2_r, {N{1'b0}}} - (3*N)'(a2_r)) + (3*N)'(den3 >> 1);

  logic           v3_r;
  logic [3*N-1:0] num3_r;
  logic [2*N-1:0] den3_r;
  logic [N-1:0]   x3_r, p3_r, w3_r;
  logic           byp3_r, xz3_r, xf3_r, dz3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num3_r <= num3_nxt;
      den3_r <= (den3 == '0) ? (2*N)'(1) : den3[2*N-1:0];
      x3_r   <= x2_r;
      p3_r   <= p2_r;
      w3_r   <= w2_r;
      byp3_r <= byp2_r;
      xz3_r  <= (x2_r == '0);
      xf3_r  <= (x2_r == FS);
      dz3_r  <= (den3 == '0);
    end
  end

  // ---------------- divider 2: s = FS*A/(A+B) ----------------
  localparam int SB2 = 3*N + 4;
  logic           v2d;
  logic [N-1:0]   q2;
  logic [SB2-1:0] side2;

  mtfps_div #(.QB(N), .DB(2*N), .SB(SB2)) u_div_mtf (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v3_r),
    .in_num   (num3_r),
    .in_den   (den3_r),
    .in_side  ({x3_r, w3_r, p3_r, byp3_r, xz3_r, xf3_r, dz3_r}),
    .out_valid(v2d),
    .out_q    (q2),
    .out_side (side2)
  );

  // ---------------- S4: blend numerator ----------------
  logic [N-1:0] s4, p4, w4, x4, diff4;
  logic         ge4;
  assign p4    = side2[N+3:4];
  assign w4    = side2[2*N+3:N+4];
  assign x4    = side2[3*N+3:2*N+4];
  assign s4    = side2[2] ? '0 : (side2[1] ? FS : (side2[0] ? x4 : q2));
  assign ge4   = (s4 >= p4);
  assign diff4 = ge4 ? (s4 - p4) : (p4 - s4);

  logic           v4_r;
  logic [2*N-1:0] num4_r;
  logic [N-1:0]   s4_r, p4_r;
  logic           ge4_r, byp4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v2d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num4_r <= ({N'(0), diff4} * {N'(0), w4}) + (2*N)'(FS >> 1);
      s4_r   <= s4;
      p4_r   <= p4;
      ge4_r  <= ge4;
      byp4_r <= side2[3];
    end
  end

  // ---------------- S5: blend divide by FS, output register ----------------
  // y/FS for y < FS*2^N equals (y + (y >> N) + 1) >> N exactly
  logic [2*N-1:0] t5;
  logic [N-1:0]   q5, r5;
  assign t5 = num4_r + (2*N)'(num4_r >> N) + (2*N)'(1);
  assign q5 = N'(t5 >> N);

  always_comb begin
    if (byp4_r) begin
      r5 = p4_r;
    end else if (!mask_r) begin
      r5 = s4_r;
    end else if (ge4_r) begin
      r5 = p4_r + q5;
    end else begin
      r5 = p4_r - q5;
    end
  end

  logic [N-1:0] pix_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_out_r <= r5;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(pix_out_r);

  // ---------------- assertions ----------------
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");
  a_enter_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted transaction missing from first stage");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for midtone_transfer_pixel_stretch_unit.
// Pixel/weight transactions go in on the in_ stream; every one returns exactly one
// stretched pixel on the out_ stream, in order. A local model of the stretch
// (normalize, midtone transfer, optional mask blend) queues the expected pixel at
// input acceptance; the output monitor pops and compares.
module tb_top;
  import mtfps_pkg::*;

  localparam int PB = 16;
  localparam logic [15:0] FS = 16'hFFFF;
  localparam int LATENCY = 2 * PB + 5;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_BLACK_POINT;
  logic [PB-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;   // [15:0] pixel_in, [31:16] mask_weight
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] pixel_out

  always #5 clk = ~clk;

  midtone_transfer_pixel_stretch_unit #(.PIXEL_BITS(PB)) DUT (.*);

  // Shadow copy of the stretch registers
  logic [15:0] blk_pt = 16'd0, wht_pt = FS, mid_lvl = 16'd16384;
  logic        mask_on = 1'b0;

  logic [15:0] pixel_expq[$];
  int  n_fail = 0, n_in = 0, n_out = 0, n_cfg = 0;
  int  send_idle_pct = 0, recv_idle_pct = 0;
  bit  recv_hold = 0;
  int  idle_cycles = 0;

  // round_half_up(a*b/c), c != 0
  function automatic logic [63:0] muldiv_rnd(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] c);
    logic [127:0] prod;
    prod = a * b + (c >> 1);
    return 64'(prod / c);
  endfunction

  function automatic logic [15:0] stretch_pixel(logic [15:0] p, logic [15:0] w);
    logic [63:0] x, m, a, b, s, lo;
    logic [15:0] r;
    if (wht_pt <= blk_pt) return p;
    if (mask_on && w == 0) return p;
    if (p <= blk_pt) x = 0;
    else if (p >= wht_pt) x = FS;
    else x = muldiv_rnd(p - blk_pt, FS, wht_pt - blk_pt);
    lo = (64'(FS) + 5000) / 10000;
    m = mid_lvl < lo ? lo : (mid_lvl > FS - lo ? FS - lo : mid_lvl);
    if (x == 0) s = 0;
    else if (x >= FS) s = FS;
    else begin
      a = (FS - m) * x;
      b = m * (FS - x);
      s = (a + b == 0) ? x : muldiv_rnd(FS, a, a + b);
      if (s > FS) s = FS;
    end
    if (!mask_on) r = s[15:0];
    else if (s >= p) r = p + 16'(muldiv_rnd(s - p, w, FS));
    else r = p - 16'(muldiv_rnd(p - s, w, FS));
    return r;
  endfunction

  // Output monitor, plus expected pixel at input acceptance
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      pixel_expq = {pixel_expq, stretch_pixel(in_tdata[15:0], in_tdata[31:16])};
      n_in++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_out++;
      if (pixel_expq.size() == 0) begin
        $display("%0t: unexpected pixel_out transaction, actual %h", $time, out_tdata);
        n_fail++;
      end else begin
        logic [15:0] exp_pix;
        exp_pix = pixel_expq.pop_front();
        if (out_tdata !== exp_pix) begin
          $display("%0t: pixel_out mismatch, expected %h actual %h", $time,
                   exp_pix, out_tdata);
          n_fail++;
        end
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off when requested
  always @(negedge clk) begin
    if (recv_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no transaction at all and no receiver hold-off
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready) || recv_hold)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired with %0d pixels outstanding", pixel_expq.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BLACK_POINT:   blk_pt  = val;
      CFG_WHITE_POINT:   wht_pt  = val;
      CFG_MIDTONE_LEVEL: mid_lvl = val;
      CFG_MASK_ENABLE:   mask_on = val[0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until the pipe is empty; registers may change only then
  task automatic drain_pipe();
    while (pixel_expq.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic load_setup(logic [15:0] b, logic [15:0] w, logic [15:0] m, bit mk);
    drain_pipe();
    cfg_write(CFG_BLACK_POINT, b);
    cfg_write(CFG_WHITE_POINT, w);
    cfg_write(CFG_MIDTONE_LEVEL, m);
    cfg_write(CFG_MASK_ENABLE, {15'd0, mk});
  endtask

  // One input transaction; valid stays high across back-to-back items
  task automatic send_pixel(logic [15:0] p, logic [15:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w, p};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return FS;
      2: return 16'($urandom_range(255));
      3: return FS - 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed rows: setup, pixel, weight, and the plainly known answer if any
  typedef struct {
    logic [15:0] blk, wht, mid;
    bit          mk;
    logic [15:0] pix, wgt;
    bit          known;
    logic [15:0] ans;
  } dir_row_t;

  dir_row_t dir_rows[21] = '{
    '{16'd0, FS, 16'd16384, 0, 16'd0,     16'd0,     1, 16'd0},
    '{16'd0, FS, 16'd16384, 0, FS,        16'd0,     1, FS},
    '{16'd0, FS, 16'd16384, 0, 16'd1,     16'hFFFF,  0, 16'd0},
    '{16'd0, FS, 16'd16384, 0, 16'h8000,  16'd0,     0, 16'd0},
    '{16'd0, FS, 16'd16384, 0, 16'hFFFE,  16'h5555,  0, 16'd0},
    // empty range: passthrough
    '{16'd5000, 16'd5000, 16'd0, 0, 16'h1234, 16'd0, 1, 16'h1234},
    '{FS, 16'd0, FS, 1, 16'hABCD, FS, 1, 16'hABCD},
    // midtone clamps at both ends
    '{16'd0, FS, 16'd0, 0, 16'h0100, 16'd0, 0, 16'd0},
    '{16'd0, FS, FS,    0, 16'hFF00, 16'd0, 0, 16'd0},
    '{16'd0, FS, 16'd1, 0, 16'h0001, 16'd0, 0, 16'd0},
    // black/white clipping
    '{16'd1000, 16'd2000, 16'd30000, 0, 16'd999,  16'd0, 1, 16'd0},
    '{16'd1000, 16'd2000, 16'd30000, 0, 16'd1000, 16'd0, 1, 16'd0},
    '{16'd1000, 16'd2000, 16'd30000, 0, 16'd2000, 16'd0, 1, FS},
    '{16'd1000, 16'd2000, 16'd30000, 0, 16'd1500, 16'd0, 0, 16'd0},
    '{16'd0, 16'd1, 16'd32768, 0, 16'd1, 16'd0, 1, FS},
    // masking: zero weight keeps the pixel, full weight takes the stretch
    '{16'd0, FS, 16'd16384, 1, 16'h4000, 16'd0, 1, 16'h4000},
    '{16'd0, FS, 16'd16384, 1, FS,       FS,    1, FS},
    '{16'd0, FS, 16'd16384, 1, 16'h4000, FS,    0, 16'd0},
    '{16'd0, FS, 16'd16384, 1, 16'h4000, 16'h8000, 0, 16'd0},
    '{16'd0, FS, 16'd60000, 1, 16'hC000, 16'h0001, 0, 16'd0},
    '{16'd0, FS, 16'd60000, 1, 16'hC000, 16'hAAAA, 0, 16'd0}
  };

  initial begin
    logic [15:0] r_blk, r_wht, r_mid;
    bit r_mk;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table; reset values are still loaded for the first rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].blk != blk_pt || dir_rows[i].wht != wht_pt ||
          dir_rows[i].mid != mid_lvl || dir_rows[i].mk != mask_on) begin
        stop_sending();
        load_setup(dir_rows[i].blk, dir_rows[i].wht, dir_rows[i].mid, dir_rows[i].mk);
      end
      if (dir_rows[i].known &&
          stretch_pixel(dir_rows[i].pix, dir_rows[i].wgt) !== dir_rows[i].ans) begin
        $display("%0t: row %0d model check, expected %h actual %h", $time, i,
                 dir_rows[i].ans, stretch_pixel(dir_rows[i].pix, dir_rows[i].wgt));
        n_fail++;
      end
      send_pixel(dir_rows[i].pix, dir_rows[i].wgt);
    end

    // Random phases: 3 idling patterns, several register setups each
    for (int ph = 0; ph < 12; ph++) begin
      case (ph / 4)
        0: begin send_idle_pct = 38; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      r_blk = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(20000));
      r_wht = ($urandom_range(3) == 0) ? FS : 16'($urandom_range(65535, 30000));
      if (ph == 5) r_wht = r_blk;            // empty range once in random part
      r_mid = (ph == 3) ? 16'd0 : (ph == 7) ? FS : 16'($urandom);
      r_mk = ph[0];
      stop_sending();
      load_setup(r_blk, r_wht, r_mid, r_mk);
      for (int k = 0; k < 94; k++) begin
        logic [15:0] w;
        w = ($urandom_range(5) == 0) ? 16'd0 :
            ($urandom_range(5) == 0) ? FS : 16'($urandom);
        send_pixel(rand_pixel(), w);
        // receiver hold-off while the sender keeps offering: the pipe fills up
        if (ph == 9 && k == 10) begin
          recv_hold = 1;
          fork
            begin repeat (200) @(negedge clk); recv_hold = 0; end
          join_none
        end
      end
      // sender pauses until every expected pixel has come back
      if (ph == 6) begin
        stop_sending();
        while (pixel_expq.size() != 0) @(negedge clk);
      end
    end
    stop_sending();
    recv_idle_pct = 0;
    while (pixel_expq.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);

    $display("covered %0d pixels in, %0d out, %0d register writes;", n_in, n_out, n_cfg);
    $display("extremes, empty range, midtone clamps, masking and back-pressure phases");
    if (n_fail == 0 && pixel_expq.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
